[sv/ais_pkg.sv]
// Shared types and constants of the appliance inspection sequencer.
package ais_pkg;

    // Field widths.
    localparam int PeriodW  = 10;
    localparam int MaskW    = 7;
    localparam int FreqW    = 20;
    localparam int WeightW  = 16;
    localparam int SpeedW   = 16;
    localparam int StepW    = 18;
    localparam int StallW   = 12;
    localparam int OverallW = 21;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 20;

    // Phase timing limits in milliseconds.
    localparam logic [StepW-1:0]    LevelWaitMs = StepW'(4000);
    localparam logic [StepW-1:0]    WashMs      = StepW'(6000);
    localparam logic [StallW-1:0]   StallMs     = StallW'(2000);
    localparam logic [StepW-1:0]    DrainMinMs  = StepW'(10000);
    localparam logic [StepW-1:0]    DrainMaxMs  = StepW'(2 * 60 * 1000);
    localparam logic [StepW-1:0]    HoldMs      = StepW'(10000);
    localparam logic [OverallW-1:0] OverallMs   = OverallW'(20 * 60 * 1000);

    // Key slots.
    localparam int KeyStart  = 0;
    localparam int KeyNext   = 1;
    localparam int KeyCold   = 2;
    localparam int KeySoft   = 3;
    localparam int KeyHot    = 4;
    localparam int KeyShower = 5;
    localparam int KeyLid    = 6;

    typedef enum logic [1:0] {
        MODE_INIT = 2'd0,
        MODE_OPER = 2'd1,
        MODE_DONE = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        PH_STANDBY = 4'd0,
        PH_VALVE   = 4'd1,
        PH_LEVEL   = 4'd2,
        PH_LOAD    = 4'd3,
        PH_WASH    = 4'd4,
        PH_DRAIN   = 4'd5,
        PH_HOLD    = 4'd6,
        PH_SPIN    = 4'd7,
        PH_ERROR   = 4'd8,
        PH_DONE    = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        ER_NONE  = 3'd0,
        ER_LEVEL = 3'd1,
        ER_MOTOR = 3'd2,
        ER_DRAIN = 3'd3,
        ER_LID   = 3'd4
    } t_error;

    typedef enum logic [2:0] {
        VC_NONE    = 3'd0,
        VC_COLD    = 3'd1,
        VC_SOFT    = 3'd2,
        VC_HOT     = 3'd3,
        VC_SHOWER  = 3'd4,
        VC_LIDLOCK = 3'd5
    } t_valve;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_FREQ_UPPER = 2'd0,
        CFG_FREQ_LOWER = 2'd1,
        CFG_KEY_MASK   = 2'd2,
        CFG_SHOWER_EN  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [PeriodW-1:0] period_ms;
        logic [MaskW-1:0]   key_pressed_mask;
        logic [MaskW-1:0]   key_down_mask;
        logic [FreqW-1:0]   level_freq;
        logic [WeightW-1:0] load_weight;
        logic [SpeedW-1:0]  motor_speed;
        logic               drain_level_reached;
        logic               lid_closed;
    } t_tick;

    typedef struct packed {
        logic [FreqW-1:0] freq_upper;
        logic [FreqW-1:0] freq_lower;
        logic [MaskW-1:0] key_mask;
        logic             shower_en;
    } t_cfg;

    typedef struct packed {
        t_phase phase;
        t_error error_code;
        t_valve valve_check;
        logic   beep;
        logic   finished;
    } t_result;

endpackage

[sv/ais_ifs.sv]
// Channel interfaces: tick requests in, result requests out, register writes.
interface ais_tick_if;
    import ais_pkg::*;

    logic               valid;
    logic               ready;
    logic [PeriodW-1:0] period_ms;
    logic [MaskW-1:0]   key_pressed_mask;
    logic [MaskW-1:0]   key_down_mask;
    logic [FreqW-1:0]   level_freq;
    logic [WeightW-1:0] load_weight;
    logic [SpeedW-1:0]  motor_speed;
    logic               drain_level_reached;
    logic               lid_closed;

    modport source (
        output valid, period_ms, key_pressed_mask, key_down_mask, level_freq,
               load_weight, motor_speed, drain_level_reached, lid_closed,
        input  ready
    );
    modport sink (
        input  valid, period_ms, key_pressed_mask, key_down_mask, level_freq,
               load_weight, motor_speed, drain_level_reached, lid_closed,
        output ready
    );
endinterface

interface ais_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] phase;
    logic [2:0] error_code;
    logic [2:0] valve_check;
    logic       beep;
    logic       finished;

    modport source (
        output valid, phase, error_code, valve_check, beep, finished,
        input  ready
    );
    modport sink (
        input  valid, phase, error_code, valve_check, beep, finished,
        output ready
    );
endinterface

interface ais_cfg_if;
    import ais_pkg::*;

    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[sv/ais_step.sv]
// Inspection state registers and the next-state logic for one tick.
module ais_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  ais_pkg::t_tick  i_tick,
    input  ais_pkg::t_cfg   i_cfg,
    output ais_pkg::t_result o_result
);
    import ais_pkg::*;

    t_mode                r_mode,    n_mode;
    t_phase               r_phase,   n_phase;
    t_error               r_error,   n_error;
    t_valve               r_valve,   n_valve;
    logic [StepW-1:0]     r_step,    n_step;
    logic [StallW-1:0]    r_stall,   n_stall;
    logic [OverallW-1:0]  r_overall, n_overall;

    logic                 beep;
    t_phase               cur_phase;
    t_valve               valve_pick;
    t_valve               valve_upd;
    logic [MaskW-1:0]     key_ok;
    logic [MaskW-1:0]     kdown;
    logic [MaskW-1:0]     kup;
    logic [MaskW-1:0]     khit;
    logic [StepW-1:0]     step_sum;
    logic [StallW-1:0]    stall_sum;
    logic [OverallW-1:0]  overall_sum;

    // Qualified key views: absent keys and a disabled shower slot are ignored.
    always_comb begin
        key_ok = i_cfg.key_mask;
        if (!i_cfg.shower_en) begin
            key_ok[KeyShower] = 1'b0;
        end
        kdown = key_ok & i_tick.key_down_mask;
        kup   = key_ok & ~i_tick.key_down_mask;
        khit  = key_ok & i_tick.key_pressed_mask;
    end

    // Timer increments, truncated to each timer's width.
    assign step_sum    = r_step + StepW'(i_tick.period_ms);
    assign stall_sum   = r_stall + StallW'(i_tick.period_ms);
    assign overall_sum = r_overall + OverallW'(i_tick.period_ms);

    // Valve check: pick a valve from an idle state, then apply the release rules.
    always_comb begin
        valve_pick = r_valve;
        if (r_valve == VC_NONE) begin
            if (kdown[KeyCold]) begin
                valve_pick = VC_COLD;
            end else if (kdown[KeySoft]) begin
                valve_pick = VC_SOFT;
            end else if (kdown[KeyHot]) begin
                valve_pick = VC_HOT;
            end else if (kdown[KeyShower]) begin
                valve_pick = VC_SHOWER;
            end else if (kdown[KeyLid]) begin
                valve_pick = VC_LIDLOCK;
            end
        end
        valve_upd = valve_pick;
        if ((kup[KeyCold] && valve_pick == VC_COLD) ||
            (kup[KeySoft] && valve_pick == VC_SOFT) ||
            (kup[KeyHot] && valve_pick == VC_HOT) ||
            (kup[KeyShower] && valve_pick == VC_SHOWER)) begin
            valve_upd = VC_NONE;
        end else if (valve_pick == VC_LIDLOCK &&
                     (kdown[KeyCold] || kdown[KeySoft] ||
                      kdown[KeyHot] || kdown[KeyShower])) begin
            valve_upd = VC_NONE;
        end
    end

    // Next state for one tick.
    always_comb begin
        n_mode    = r_mode;
        n_phase   = r_phase;
        n_error   = r_error;
        n_valve   = r_valve;
        n_step    = r_step;
        n_stall   = r_stall;
        n_overall = r_overall;
        beep      = 1'b0;
        cur_phase = r_phase;
        unique case (r_mode)
            MODE_INIT: begin
                n_mode  = MODE_OPER;
                n_phase = PH_STANDBY;
                n_error = ER_NONE;
                n_valve = VC_NONE;
            end
            MODE_OPER: begin
                // The overall timeout overrides whatever phase is running.
                if (r_overall > OverallMs) begin
                    cur_phase = PH_DONE;
                end else begin
                    n_overall = overall_sum;
                end
                n_phase = cur_phase;
                case (cur_phase)
                    PH_STANDBY: begin
                        if (khit[KeyStart]) begin
                            beep    = 1'b1;
                            n_phase = PH_VALVE;
                        end
                    end
                    PH_VALVE: begin
                        if (khit[KeyNext]) begin
                            beep    = 1'b1;
                            n_phase = PH_LEVEL;
                        end
                        n_valve = valve_upd;
                    end
                    PH_LEVEL: begin
                        if (r_step >= LevelWaitMs) begin
                            n_step = '0;
                            if (i_tick.level_freq > i_cfg.freq_upper &&
                                i_tick.level_freq < i_cfg.freq_lower) begin
                                n_error = ER_NONE;
                                n_phase = PH_LOAD;
                            end else begin
                                n_error = ER_LEVEL;
                                n_phase = PH_ERROR;
                            end
                        end else begin
                            n_step = step_sum;
                        end
                    end
                    PH_LOAD: begin
                        if (i_tick.load_weight != '0) begin
                            n_phase = PH_WASH;
                        end
                    end
                    PH_WASH: begin
                        if (r_step >= WashMs) begin
                            n_step  = '0;
                            n_phase = PH_DRAIN;
                        end else begin
                            n_step = step_sum;
                            // A stopped drum accumulates stall time.
                            if (i_tick.motor_speed == '0) begin
                                n_stall = stall_sum;
                                if (stall_sum >= StallMs) begin
                                    n_error = ER_MOTOR;
                                    n_phase = PH_ERROR;
                                end
                            end else begin
                                n_stall = '0;
                            end
                        end
                    end
                    PH_DRAIN: begin
                        if (r_step >= DrainMinMs && i_tick.drain_level_reached) begin
                            n_step  = '0;
                            n_phase = PH_HOLD;
                        end else if (r_step >= DrainMaxMs) begin
                            n_step  = '0;
                            n_error = ER_DRAIN;
                            n_phase = PH_ERROR;
                        end else begin
                            n_step = step_sum;
                        end
                    end
                    PH_HOLD: begin
                        if (r_step >= HoldMs) begin
                            n_step = '0;
                            if (i_tick.lid_closed) begin
                                n_phase = PH_SPIN;
                            end else begin
                                n_error = ER_LID;
                                n_phase = PH_ERROR;
                            end
                        end else begin
                            n_step = step_sum;
                        end
                    end
                    PH_ERROR: begin
                        // A lid error recovers once the lid is closed.
                        if (r_error == ER_LID && i_tick.lid_closed) begin
                            n_step  = '0;
                            n_phase = PH_SPIN;
                        end
                    end
                    PH_DONE: begin
                        n_mode = MODE_DONE;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Result of the tick, taken from the updated state.
    always_comb begin
        o_result.phase       = n_phase;
        o_result.error_code  = n_error;
        o_result.valve_check = n_valve;
        o_result.beep        = beep;
        o_result.finished    = (n_mode == MODE_DONE);
    end

    // State registers advance once per tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_INIT;
            r_phase   <= PH_STANDBY;
            r_error   <= ER_NONE;
            r_valve   <= VC_NONE;
            r_step    <= '0;
            r_stall   <= '0;
            r_overall <= '0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_phase   <= n_phase;
            r_error   <= n_error;
            r_valve   <= n_valve;
            r_step    <= n_step;
            r_stall   <= n_stall;
            r_overall <= n_overall;
        end
    end

    // Done is final and always shows the done phase.
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_DONE |=> r_mode == MODE_DONE)
        else $error("done mode was left");

    a_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_DONE |-> r_phase == PH_DONE)
        else $error("done mode without done phase");

    // The error phase is only ever entered with a cause recorded.
    a_error_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_ERROR |-> r_error != ER_NONE)
        else $error("error phase without error code");

endmodule

[sv/appliance_inspection_sequencer_unit.sv]
// Top level of the appliance inspection sequencer: handshakes, registers and result stage.
//
// Each tick request yields exactly one result request. A tick is captured in
// an input register, the state update and the result are computed in one
// pass of compare-and-add logic, and the result lands in an output register
// once that register is free or draining. The block sustains one tick per
// cycle while the result consumer is ready; that rate is set by the single
// state update per tick in the sequencing step. A stalled result consumer
// holds the output register and, once the input register is also full,
// back-pressures the tick channel. Register writes are always ready and take
// effect in the following cycle; they are meant to be made while no tick is in flight.
module appliance_inspection_sequencer_unit (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ais_tick_if.sink   i_tick,
    ais_cfg_if.sink    i_cfg,
    ais_res_if.source  o_res
);
    import ais_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_tick   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result step_result;
    logic    advance;

    // The input stage moves on when the output register is free or draining.
    assign advance      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_tick.ready = !r_in_valid || advance;
    assign i_cfg.ready  = 1'b1;

    // Register file writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_FREQ_UPPER: r_cfg.freq_upper <= i_cfg.data[FreqW-1:0];
                CFG_FREQ_LOWER: r_cfg.freq_lower <= i_cfg.data[FreqW-1:0];
                CFG_KEY_MASK:   r_cfg.key_mask   <= i_cfg.data[MaskW-1:0];
                CFG_SHOWER_EN:  r_cfg.shower_en  <= i_cfg.data[0];
            endcase
        end
    end

    // Input register: valid flag under reset, payload without.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_tick.ready) begin
            r_in_valid <= i_tick.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_in.period_ms           <= i_tick.period_ms;
            r_in.key_pressed_mask    <= i_tick.key_pressed_mask;
            r_in.key_down_mask       <= i_tick.key_down_mask;
            r_in.level_freq          <= i_tick.level_freq;
            r_in.load_weight         <= i_tick.load_weight;
            r_in.motor_speed         <= i_tick.motor_speed;
            r_in.drain_level_reached <= i_tick.drain_level_reached;
            r_in.lid_closed          <= i_tick.lid_closed;
        end
    end

    // Sequencing step.
    ais_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_tick   (r_in),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.phase       = r_out.phase;
    assign o_res.error_code  = r_out.error_code;
    assign o_res.valve_check = r_out.valve_check;
    assign o_res.beep        = r_out.beep;
    assign o_res.finished    = r_out.finished;

    // A taken tick is held in the input stage on the next cycle.
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick.valid && i_tick.ready |=> r_in_valid)
        else $error("accepted tick was not captured");

    // Every step produces a pending result.
    a_out_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("step result was not registered");

    // A finished result always reports the done phase.
    a_finished_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.finished |-> r_out.phase == PH_DONE)
        else $error("finished flag without done phase");

endmodule
